@@ hw/rtl/crcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

  localparam int          HEADER_BYTES = 4;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;

  localparam logic [7:0]  POS_LENGTH   = 8'd0;
  localparam logic [7:0]  POS_ID       = 8'd1;
  localparam logic [7:0]  POS_SPARE    = 8'd2;

  typedef struct packed {
    logic       still_receiving;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       frame_good;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
  } result_t;

  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crcfr_engine.sv @@
// ----------------------------------------------------------------------------
// crcfr_engine
// Frame state registers and per-byte decode: position, length, id and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_engine
  import crcfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output result_t         result
);

  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  message_id, message_id_next;
  logic [15:0] running_crc, running_crc_next;

  logic [8:0]  crc_low_pos;
  logic [8:0]  length_total;
  logic [15:0] crc_fed;
  logic        idle;

  always_comb begin
    crc_low_pos  = 9'(HEADER_BYTES - 1) + {1'b0, payload_length};
    length_total = 9'(HEADER_BYTES) + {1'b0, rx_byte};
    crc_fed      = crc16_feed((byte_position == POS_LENGTH) ? CRC_INIT : running_crc, rx_byte);

    payload_length_next = payload_length;
    message_id_next     = message_id;
    running_crc_next    = running_crc;
    result              = '0;
    idle                = 1'b0;

    priority if (byte_position == POS_LENGTH) begin
      if (length_total > 9'(BUFFER_BYTES)) begin
        idle = 1'b1;
      end else begin
        payload_length_next = rx_byte;
        running_crc_next    = crc_fed;
      end
    end else if (byte_position == POS_ID) begin
      message_id_next  = rx_byte;
      running_crc_next = crc_fed;
    end else if (byte_position == POS_SPARE) begin
      running_crc_next = crc_fed;
    end else if ({1'b0, byte_position} < crc_low_pos) begin
      running_crc_next     = crc_fed;
      result.payload_valid = 1'b1;
      result.payload_index = byte_position - 8'(HEADER_BYTES - 1);
      result.payload_byte  = rx_byte;
    end else if ({1'b0, byte_position} == crc_low_pos) begin
      idle = (rx_byte != running_crc[7:0]);
    end else begin
      if (rx_byte == running_crc[15:8]) begin
        result.frame_good   = 1'b1;
        result.frame_id     = message_id;
        result.frame_length = payload_length;
      end
      idle = 1'b1;
    end

    result.still_receiving = !idle;
    byte_position_next     = idle ? POS_LENGTH : byte_position + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= POS_LENGTH;
      payload_length <= '0;
      message_id     <= '0;
      running_crc    <= CRC_INIT;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      payload_length <= payload_length_next;
      message_id     <= message_id_next;
      running_crc    <= running_crc_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crcfr_skid.sv @@
// ----------------------------------------------------------------------------
// crcfr_skid
// Output register with one skid entry for result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_skid
  import crcfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crc_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// crc_frame_receiver
// Length-prefixed frame receiver with reflected CCITT CRC-16 check.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one received byte per beat (start character stripped):
//   length, id, spare, payload, CRC low, CRC high. Every input beat yields
//   exactly one result beat on the master side.
//   Result beat carries the payload byte with its index when payload_valid,
//   and frame_good with id and length on the beat of a matching CRC high byte.
//   still_receiving low marks the byte on which the receiver went idle:
//   oversized length, bad CRC low byte, or end of frame.
//   A result beat is registered in the skid output register, or in the skid
//   entry on a stall. Throughput: one byte per cycle while s_tready is high;
//   CRC update and position compare are combinational on the frame state.
//   Reset: position cleared, CRC set to 0xFFFF, no result pending.
//   Stall: a held result keeps its value; one more byte lands in the skid
//   entry, then s_tready drops until the master side drains.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_frame_receiver
  import crcfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] payload_index, [15:8] payload_byte,
                                      // [23:16] frame_id, [31:24] frame_length
  output logic [2:0]       m_tuser    // [0] still_receiving, [1] payload_valid,
                                      // [2] frame_good
);

  result_t result;
  result_t out_result;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  crcfr_engine #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .rx_byte(s_tdata),
    .result (result)
  );

  crcfr_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (result),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_result)
  );

  assign m_tdata = {out_result.frame_length, out_result.frame_id,
                    out_result.payload_byte, out_result.payload_index};
  assign m_tuser = {out_result.frame_good, out_result.payload_valid,
                    out_result.still_receiving};

endmodule

`default_nettype wire

@@ hw/rtl/crcfr_checker.sv @@
// ----------------------------------------------------------------------------
// crcfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_good_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[1])
    else $error("good frame flag with payload or still receiving");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[15:0] == 16'h0000)
    else $error("payload fields set without payload_valid");

  a_one_to_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
    else $error("accepted byte produced no result beat");

endmodule

bind crc_frame_receiver crcfr_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for crc_frame_receiver. Streams received bytes into the slave
// side and checks every result beat against a directed row's own value or
// a predictor of the frame state (position, length, id, running CRC-16).
// A short table of directed rows covers the header, payload and CRC cases.
// Random frames with random content follow, some of them oversized, cut
// short or with corrupted CRC bytes, and random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import crcfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_BYTES   = 64;
  localparam int MAX_PAYLOAD    = BUFFER_BYTES - HEADER_BYTES;
  localparam int RANDOM_BYTES   = 1750;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum logic [2:0] {
    ROW_DATA,
    ROW_CRC_LO,
    ROW_CRC_HI,
    ROW_CRC_LO_BAD,
    ROW_CRC_HI_BAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;
    logic       typed;
    result_t    exp;
  } stim_row_t;

  localparam result_t RES_IDLE = '{1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
  localparam result_t RES_BUSY = '{1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
  localparam int      NUM_ROWS = 27;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  logic [7:0]  rx_pos;
  logic [7:0]  rx_len;
  logic [7:0]  rx_id;
  logic [15:0] rx_crc;

  result_t     expected_beats[$];
  int          error_count = 0;
  int          bytes_sent = 0;
  int          calm_left = 0;
  bit          long_hold_req = 1'b0;
  stim_row_t   directed_rows [NUM_ROWS];

  crc_frame_receiver #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] crc_absorb(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic result_t frame_rx_predict(logic [7:0] b);
    result_t res;
    int      crc_low_pos;
    bit      idle;
    res = '0;
    idle = 1'b0;
    crc_low_pos = HEADER_BYTES - 1 + int'(rx_len);
    if (rx_pos == POS_LENGTH) begin
      if (HEADER_BYTES + int'(b) > BUFFER_BYTES) begin
        idle = 1'b1;
      end else begin
        rx_len = b;
        rx_crc = crc_absorb(CRC_INIT, b);
      end
    end else if (rx_pos == POS_ID) begin
      rx_id  = b;
      rx_crc = crc_absorb(rx_crc, b);
    end else if (rx_pos == POS_SPARE) begin
      rx_crc = crc_absorb(rx_crc, b);
    end else if (int'(rx_pos) < crc_low_pos) begin
      rx_crc = crc_absorb(rx_crc, b);
      res.payload_valid = 1'b1;
      res.payload_index = rx_pos - 8'(HEADER_BYTES - 1);
      res.payload_byte  = b;
    end else if (int'(rx_pos) == crc_low_pos) begin
      if (b != rx_crc[7:0]) idle = 1'b1;
    end else begin
      if (b == rx_crc[15:8]) begin
        res.frame_good   = 1'b1;
        res.frame_id     = rx_id;
        res.frame_length = rx_len;
      end
      idle = 1'b1;
    end
    res.still_receiving = !idle;
    rx_pos = idle ? 8'd0 : rx_pos + 8'd1;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_exp);
    int      gap;
    result_t predicted;
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (calm_left > 0) calm_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predicted = frame_rx_predict(b);
    expected_beats.push_back(typed ? typed_exp : predicted);
    bytes_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, 1'b0, RES_IDLE);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic send_frame();
    int         r;
    int         len;
    logic [7:0] lo_mask;
    logic [7:0] hi_mask;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_plain(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      return;
    end
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) send_plain(8'($urandom_range(0, 255)));
      while (rx_pos != POS_LENGTH) send_plain(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 18) len = MAX_PAYLOAD;
    else if (r < 22) len = $urandom_range(13, MAX_PAYLOAD);
    else len = $urandom_range(0, 12);
    r = $urandom_range(0, 99);
    lo_mask = (r < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
    hi_mask = (r >= 10 && r < 20) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_plain(8'(len));
    send_plain(8'($urandom_range(0, 255)));
    send_plain(8'($urandom_range(0, 255)));
    repeat (len) send_plain(8'($urandom_range(0, 255)));
    send_plain(rx_crc[7:0] ^ lo_mask);
    if (lo_mask == 8'h00) send_plain(rx_crc[15:8] ^ hi_mask);
  endtask

  initial begin
    int           frames;
    logic [7:0]   b;
    directed_rows = '{
      '{ROW_DATA,       8'd0,   1'b1, RES_BUSY},
      '{ROW_DATA,       8'hFF,  1'b1, RES_BUSY},
      '{ROW_DATA,       8'h00,  1'b1, RES_BUSY},
      '{ROW_CRC_LO,     8'h00,  1'b0, RES_IDLE},
      '{ROW_CRC_HI,     8'h00,  1'b1, '{1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'hFF, 8'd0}},
      '{ROW_DATA,       8'd61,  1'b1, RES_IDLE},
      '{ROW_DATA,       8'hFF,  1'b1, RES_IDLE},
      '{ROW_DATA,       8'd2,   1'b1, RES_BUSY},
      '{ROW_DATA,       8'h00,  1'b1, RES_BUSY},
      '{ROW_DATA,       8'hFF,  1'b1, RES_BUSY},
      '{ROW_DATA,       8'h00,  1'b0, RES_IDLE},
      '{ROW_DATA,       8'hFF,  1'b0, RES_IDLE},
      '{ROW_CRC_LO_BAD, 8'h01,  1'b1, RES_IDLE},
      '{ROW_DATA,       8'd1,   1'b1, RES_BUSY},
      '{ROW_DATA,       8'h5A,  1'b1, RES_BUSY},
      '{ROW_DATA,       8'hA5,  1'b1, RES_BUSY},
      '{ROW_DATA,       8'h80,  1'b0, RES_IDLE},
      '{ROW_CRC_LO,     8'h00,  1'b0, RES_IDLE},
      '{ROW_CRC_HI_BAD, 8'h80,  1'b1, RES_IDLE},
      '{ROW_DATA,       8'd3,   1'b1, RES_BUSY},
      '{ROW_DATA,       8'd7,   1'b1, RES_BUSY},
      '{ROW_DATA,       8'h00,  1'b1, RES_BUSY},
      '{ROW_DATA,       8'h01,  1'b0, RES_IDLE},
      '{ROW_DATA,       8'h7F,  1'b0, RES_IDLE},
      '{ROW_DATA,       8'hFE,  1'b0, RES_IDLE},
      '{ROW_CRC_LO,     8'h00,  1'b0, RES_IDLE},
      '{ROW_CRC_HI,     8'h00,  1'b1, '{1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 8'd7, 8'd3}}
    };
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    rx_pos   = 8'd0;
    rx_len   = 8'd0;
    rx_id    = 8'd0;
    rx_crc   = CRC_INIT;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CRC_LO:     b = rx_crc[7:0];
        ROW_CRC_HI:     b = rx_crc[15:8];
        ROW_CRC_LO_BAD: b = rx_crc[7:0] ^ directed_rows[i].data;
        ROW_CRC_HI_BAD: b = rx_crc[15:8] ^ directed_rows[i].data;
        default:        b = directed_rows[i].data;
      endcase
      send_byte(b, directed_rows[i].typed, directed_rows[i].exp);
    end
    wait_drained();

    long_hold_req = 1'b1;
    frames = 0;
    while (bytes_sent < NUM_ROWS + RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 80);
      if (frames == 60 || $urandom_range(0, 49) == 0) wait_drained();
      send_frame();
      frames++;
    end
    while (rx_pos != POS_LENGTH) send_plain(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    int unsigned open_left;
    hold_left = 0;
    open_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !rst && hold_left == 0) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (open_left != 0) begin
        open_left--;
        m_tready <= 1'b1;
      end else begin
        hold_left = pick_gap();
        open_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
        m_tready <= (hold_left == 0);
        if (hold_left != 0) hold_left--;
      end
    end
  end

  task automatic check_field(input string field, input logic [7:0] exp, input logic [7:0] got);
    if (exp !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, exp, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got.still_receiving = m_tuser[0];
      got.payload_valid   = m_tuser[1];
      got.frame_good      = m_tuser[2];
      got.payload_index   = m_tdata[7:0];
      got.payload_byte    = m_tdata[15:8];
      got.frame_id        = m_tdata[23:16];
      got.frame_length    = m_tdata[31:24];
      if (expected_beats.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got %0h", $time, got);
        error_count++;
      end else begin
        exp = expected_beats.pop_front();
        check_field("still_receiving", 8'(exp.still_receiving), 8'(got.still_receiving));
        check_field("payload_valid", 8'(exp.payload_valid), 8'(got.payload_valid));
        check_field("payload_index", exp.payload_index, got.payload_index);
        check_field("payload_byte", exp.payload_byte, got.payload_byte);
        check_field("frame_good", 8'(exp.frame_good), 8'(got.frame_good));
        check_field("frame_id", exp.frame_id, got.frame_id);
        check_field("frame_length", exp.frame_length, got.frame_length);
      end
    end
  end

endmodule

`default_nettype wire
